### design/fene_pkg.sv
// Package for the FENE bond force block: formats, register indexes and constants.
// No dependencies; used by fene_bond_force_top.
`timescale 1ns / 1ps
`default_nettype none
package fene_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 20;

  localparam logic [7:0] REG_SPRING_K = 8'd0;
  localparam logic [7:0] REG_MAX_SEP  = 8'd1;

  localparam logic [23:0] MAX_SEP_RESET = 24'd1 << FRAC_BITS;
  localparam logic [31:0] LN2_Q32       = 32'd2977044472;
  localparam logic [39:0] POS_CAP       = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] NEG_CAP       = 40'h80_0000_0000;
  localparam logic [39:0] ENERGY_CAP    = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] ACC_CAP       = 48'hFFFF_FFFF_FFFF;
  localparam logic [19:0] COUNTED_CAP   = 20'hF_FFFF;
endpackage
`default_nettype wire

### design/fene_bond_force_top.sv
// FENE bond force and energy with pass statistics, iterative on one shared multiplier.
// Depends on fene_pkg.
//
// Usage: one bond separation vector (sep_x/y/z, signed Q8.16) is taken per transaction
// on the input channel (in_valid/in_stall) with has_bond, pass_start and pass_end flags.
// One result transaction per input appears on the output channel (out_valid/out_stall):
// force on the second particle, bond energy, broken flag, running energy sum and bond
// count, and at pass end the square roots of the pass minimum and maximum r squared.
// From the accepting edge to the result load, an empty, broken or fully extended bond
// takes the three squares only, and an intact bond also runs a 64-step restoring divider,
// normalise shifts, 16 log squarings and multiply steps on one 32x32 multiplier; when
// pass_end is set, square-root steps for the pass minimum and maximum follow.
// One item is in work at a time; in_stall is high until its result is loaded into the
// output register, so the next transaction is taken in the cycle after the load at best.
// A stalled output holds its result; the next item may be taken meanwhile and waits
// to load until the output register frees.
// Reset (rst, synchronous) restores spring_k = 0, max_sep = 1.0 and clears the pass
// statistics. Make configuration writes (cfg_write, cfg_index, cfg_data) only while idle.
`timescale 1ns / 1ps
`default_nettype none
module fene_bond_force_top #(
  parameter int COUNT_BITS = fene_pkg::COUNT_BITS
) (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  logic               cfg_write,
  input  wire  logic [7:0]         cfg_index,
  input  wire  logic [23:0]        cfg_data,
  input  wire  logic               in_valid,
  output logic                     in_stall,
  input  wire  logic signed [23:0] sep_x,
  input  wire  logic signed [23:0] sep_y,
  input  wire  logic signed [23:0] sep_z,
  input  wire  logic               has_bond,
  input  wire  logic               pass_start,
  input  wire  logic               pass_end,
  output logic                     out_valid,
  input  wire  logic               out_stall,
  output logic signed [39:0]       force_x,
  output logic signed [39:0]       force_y,
  output logic signed [39:0]       force_z,
  output logic [39:0]              bond_energy,
  output logic                     broken,
  output logic [47:0]              energy_total,
  output logic [19:0]              bonds_counted,
  output logic [23:0]              min_extent,
  output logic [23:0]              max_extent,
  output logic                     stats_valid
);

  typedef enum logic [18:0] {
    S_IDLE = 19'd1 << 0,
    S_R0   = 19'd1 << 1,
    S_SQ   = 19'd1 << 2,
    S_STAT = 19'd1 << 3,
    S_DIV  = 19'd1 << 4,
    S_KR0  = 19'd1 << 5,
    S_KR1  = 19'd1 << 6,
    S_F0   = 19'd1 << 7,
    S_F1   = 19'd1 << 8,
    S_M0   = 19'd1 << 9,
    S_M1   = 19'd1 << 10,
    S_NORM = 19'd1 << 11,
    S_LOG  = 19'd1 << 12,
    S_LN   = 19'd1 << 13,
    S_E0   = 19'd1 << 14,
    S_E1   = 19'd1 << 15,
    S_ACC  = 19'd1 << 16,
    S_SQRT = 19'd1 << 17,
    S_OUT  = 19'd1 << 18
  } state_t;

  state_t state;

  logic [23:0] spring_k;
  logic [23:0] max_sep;
  logic [47:0] energy_acc;
  logic [47:0] min_sq_sep;
  logic [47:0] max_sq_sep;
  logic [COUNT_BITS-1:0] bond_tally;

  logic [23:0] mag [3];
  logic [2:0]  neg;
  logic        bond_f, start_f, end_f;

  logic [1:0]  idx;
  logic [5:0]  cnt;
  logic [47:0] r0sq, r2, d;
  logic [47:0] rem, quo, num_sh;
  logic        quo_sat;
  logic [63:0] tmp;
  logic [39:0] kr;
  logic [55:0] fmag;
  logic [47:0] norm;
  logic [30:0] y;
  logic [15:0] frac;
  logic [4:0]  lg_int;
  logic [21:0] ln;
  logic [23:0] root, min_root, max_root;
  logic        sel;
  logic [39:0] frc [3];
  logic [39:0] energy;
  logic        brk;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_R0:   begin mul_a = 32'(max_sep);       mul_b = 32'(max_sep); end
      S_SQ:   begin mul_a = 32'(mag[idx]);      mul_b = 32'(mag[idx]); end
      S_KR0:  begin mul_a = 32'(spring_k);      mul_b = r0sq[31:0]; end
      S_KR1:  begin mul_a = 32'(spring_k);      mul_b = 32'(r0sq[47:32]); end
      S_F0:   begin mul_a = 32'(spring_k);      mul_b = quo[31:0]; end
      S_F1:   begin mul_a = 32'(spring_k);      mul_b = 32'(quo[47:32]); end
      S_M0:   begin mul_a = fmag[31:0];         mul_b = 32'(mag[idx]); end
      S_M1:   begin mul_a = 32'(fmag[55:32]);   mul_b = 32'(mag[idx]); end
      S_LOG:  begin mul_a = 32'(y);             mul_b = 32'(y); end
      S_LN:   begin mul_a = 32'({lg_int, frac}); mul_b = fene_pkg::LN2_Q32; end
      S_E0:   begin mul_a = kr[31:0];           mul_b = 32'(ln); end
      S_E1:   begin mul_a = 32'(kr[39:32]);     mul_b = 32'(ln); end
      S_SQRT: begin
        mul_a = 32'(root | (24'd1 << (5'd23 - cnt[4:0])));
        mul_b = mul_a;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // divider step
  logic [48:0] rem_sh;
  logic        div_ge;
  logic [47:0] rem_n;
  assign rem_sh = {rem, num_sh[47]};
  assign div_ge = rem_sh >= {1'b0, d};
  assign rem_n  = div_ge ? 48'(rem_sh - {1'b0, d}) : rem_sh[47:0];

  // statistics update, restarting the pass statistics when pass_start is set
  logic [47:0] min_b, max_b, acc_b;
  logic [COUNT_BITS-1:0] tally_b;
  assign min_b   = start_f ? r0sq : min_sq_sep;
  assign max_b   = start_f ? '0 : max_sq_sep;
  assign acc_b   = start_f ? '0 : energy_acc;
  assign tally_b = start_f ? '0 : bond_tally;

  // force component from the second partial product
  logic        m_sat;
  logic [40:0] m_sum;
  logic [39:0] m_cap, m_val;
  assign m_sat = mul_p[47:23] != '0;
  assign m_sum = 41'({mul_p[22:0], 16'b0}) + 41'(tmp[39:0]);
  assign m_cap = neg[idx] ? fene_pkg::POS_CAP : fene_pkg::NEG_CAP;
  assign m_val = (m_sat || m_sum > 41'(m_cap)) ? m_cap : m_sum[39:0];

  // log squaring step
  logic [31:0] y_sq;
  assign y_sq = mul_p[61:30];

  // energy product
  logic [63:0] e_full;
  assign e_full = {mul_p[31:0], 32'b0} + tmp;

  logic [48:0] acc_sum;
  assign acc_sum = {1'b0, energy_acc} + 49'(energy);

  logic [23:0] root_n;
  assign root_n = (mul_p[47:0] <= (sel ? max_sq_sep : min_sq_sep))
                  ? (root | (24'd1 << (5'd23 - cnt[4:0]))) : root;

  logic [32:0] tally_ext;
  assign tally_ext = 33'(bond_tally);

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      spring_k   <= '0;
      max_sep    <= fene_pkg::MAX_SEP_RESET;
      energy_acc <= '0;
      min_sq_sep <= 48'(fene_pkg::MAX_SEP_RESET) * 48'(fene_pkg::MAX_SEP_RESET);
      max_sq_sep <= '0;
      bond_tally <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          fene_pkg::REG_SPRING_K: spring_k <= cfg_data;
          fene_pkg::REG_MAX_SEP:  max_sep  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag[0]  <= sep_x[23] ? 24'(-sep_x) : sep_x;
            mag[1]  <= sep_y[23] ? 24'(-sep_y) : sep_y;
            mag[2]  <= sep_z[23] ? 24'(-sep_z) : sep_z;
            neg     <= {sep_z[23], sep_y[23], sep_x[23]};
            bond_f  <= has_bond;
            start_f <= pass_start;
            end_f   <= pass_end;
            state   <= S_R0;
          end
        end
        S_R0: begin
          r0sq  <= mul_p[47:0];
          r2    <= '0;
          idx   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          r2 <= r2 + mul_p[47:0];
          if (idx == 2'd2) state <= S_STAT;
          else idx <= idx + 2'd1;
        end
        S_STAT: begin
          energy_acc <= acc_b;
          bond_tally <= tally_b;
          if (bond_f) begin
            min_sq_sep <= (r2 < min_b) ? r2 : min_b;
            max_sq_sep <= (r2 > max_b) ? r2 : max_b;
          end else begin
            min_sq_sep <= min_b;
            max_sq_sep <= max_b;
          end
          brk    <= bond_f && (r2 > r0sq);
          d       <= r0sq - r2;
          rem     <= '0;
          quo     <= '0;
          quo_sat <= 1'b0;
          num_sh  <= r0sq;
          cnt     <= '0;
          root    <= '0;
          sel     <= 1'b0;
          if (!bond_f || r2 > r0sq) begin
            energy <= '0;
            frc[0] <= '0;
            frc[1] <= '0;
            frc[2] <= '0;
            state  <= end_f ? S_SQRT : S_OUT;
          end else if (r2 == r0sq) begin
            energy <= fene_pkg::ENERGY_CAP;
            for (int i = 0; i < 3; i++) begin
              if (mag[i] == '0) frc[i] <= '0;
              else frc[i] <= neg[i] ? fene_pkg::POS_CAP : fene_pkg::NEG_CAP;
            end
            state <= S_ACC;
          end else begin
            energy <= '0;
            frc[0] <= '0;
            frc[1] <= '0;
            frc[2] <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_n;
          quo     <= {quo[46:0], div_ge};
          quo_sat <= quo_sat | quo[47];
          num_sh  <= {num_sh[46:0], 1'b0};
          cnt     <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_KR0;
        end
        S_KR0: begin
          if (quo_sat) quo <= fene_pkg::ACC_CAP;
          tmp   <= mul_p;
          state <= S_KR1;
        end
        S_KR1: begin
          kr    <= 40'(mul_p) + 40'(tmp[63:32]);
          state <= S_F0;
        end
        S_F0: begin
          tmp   <= mul_p;
          state <= S_F1;
        end
        S_F1: begin
          fmag  <= 56'({mul_p[39:0], 16'b0}) + 56'(tmp[63:16]);
          idx   <= '0;
          state <= S_M0;
        end
        S_M0: begin
          tmp   <= 64'(mul_p[63:16]);
          state <= S_M1;
        end
        S_M1: begin
          frc[idx] <= neg[idx] ? m_val : 40'(-m_val);
          if (idx == 2'd2) begin
            norm  <= quo;
            cnt   <= '0;
            state <= S_NORM;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_M0;
          end
        end
        S_NORM: begin
          if (norm[47]) begin
            y      <= norm[47:17];
            lg_int <= (cnt <= 6'd31) ? 5'(6'd31 - cnt) : '0;
            frac   <= '0;
            cnt    <= '0;
            state  <= S_LOG;
          end else begin
            norm <= {norm[46:0], 1'b0};
            cnt  <= cnt + 6'd1;
          end
        end
        S_LOG: begin
          frac <= {frac[14:0], y_sq[31]};
          y    <= y_sq[31] ? y_sq[31:1] : y_sq[30:0];
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd15) state <= S_LN;
        end
        S_LN: begin
          ln    <= 22'((mul_p + 64'h8000_0000) >> 32);
          state <= S_E0;
        end
        S_E0: begin
          tmp   <= mul_p;
          state <= S_E1;
        end
        S_E1: begin
          energy <= (e_full[63:57] != '0) ? fene_pkg::ENERGY_CAP : e_full[56:17];
          state  <= S_ACC;
        end
        S_ACC: begin
          energy_acc <= acc_sum[48] ? fene_pkg::ACC_CAP : acc_sum[47:0];
          if (bond_tally != '1) bond_tally <= bond_tally + COUNT_BITS'(1);
          cnt   <= '0;
          root  <= '0;
          sel   <= 1'b0;
          state <= end_f ? S_SQRT : S_OUT;
        end
        S_SQRT: begin
          if (cnt == 6'd23) begin
            cnt  <= '0;
            root <= '0;
            if (!sel) begin
              min_root <= root_n;
              sel      <= 1'b1;
            end else begin
              max_root <= root_n;
              state    <= S_OUT;
            end
          end else begin
            root <= root_n;
            cnt  <= cnt + 6'd1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            force_x       <= frc[0];
            force_y       <= frc[1];
            force_z       <= frc[2];
            bond_energy   <= energy;
            broken        <= brk;
            energy_total  <= energy_acc;
            bonds_counted <= (tally_ext > 33'(fene_pkg::COUNTED_CAP))
                             ? fene_pkg::COUNTED_CAP : tally_ext[19:0];
            min_extent    <= end_f ? min_root : '0;
            max_extent    <= end_f ? max_root : '0;
            stats_valid   <= end_f;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
